FILE: hw/rtl/lmsaf_pkg.sv
// shared types and constants for the lms adaptive fir filter
`default_nettype none

package lmsaf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 16;
    localparam int ERR_W    = 17;
    localparam int COEF_W   = 24;

    // shared multiplier operand and product widths
    localparam int MUL_A_W  = 35;
    localparam int MUL_B_W  = 17;
    localparam int MUL_P_W  = 52;

    // mu * error product width
    localparam int MUE_W    = 34;

    // filter product: bits [39:20] are the q.15 term after floor shift
    localparam int TERM_HI  = 39;
    localparam int TERM_LO  = 20;
    localparam int TERM_W   = TERM_HI - TERM_LO + 1;

    // update product: bits [51:26] are the q.20 increment after floor shift
    localparam int DELTA_HI = 51;
    localparam int DELTA_LO = 26;
    localparam int DELTA_W  = DELTA_HI - DELTA_LO + 1;

    localparam int COEF_SUM_W = 27;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd5793;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic signed [COEF_SUM_W-1:0] COEF_MAX = 27'sd8388607;
    localparam logic signed [COEF_SUM_W-1:0] COEF_MIN = -27'sd8388608;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ACC,
        S_ERR,
        S_MUE,
        S_UPD,
        S_WB,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_MAC,
        MUL_MUE,
        MUL_UPD
    } t_mul_sel;

endpackage

`default_nettype wire

FILE: hw/rtl/lms_adaptive_fir_filter_core.sv
// lms adaptive fir filter core with one shared multiplier
`default_nettype none

// LMS adaptive FIR filter, NUM_TAPS taps. Each input beat brings a Q1.15
// sample and a Q1.15 desired value; each one yields exactly one output beat
// with the saturated filter output (formed with the coefficients held before
// the beat) and the error desired - output. Coefficients are Q4.20, saturate
// at 24 bits, and gain floor(mu * error * tap / 2^26) each beat; mu is the
// unsigned Q0.16 step size written through i_cfg_we / i_cfg_wdata (reset
// 5793), to be written only while the block is idle. One signed 35x17
// multiplier does all the work under a small sequencer: NUM_TAPS filter
// products, one mu * error product, then NUM_TAPS coefficient updates. An
// input beat therefore keeps the block busy through all of these steps before
// o_in_ready returns; the result sits in an output register, so a stalled
// output side only holds the block once a second result is ready.
// Delay line and coefficients are rotating registers read at tap 0, so no
// memory and no clearing pass is needed: reset clears them at once.
module lms_adaptive_fir_filter_core
    import lmsaf_pkg::*;
#(
    parameter int NUM_TAPS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    // step size register
    input  wire logic                       i_cfg_we,
    input  wire logic [STEP_W-1:0]          i_cfg_wdata,

    // input channel
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_in,
    input  wire logic signed [SAMPLE_W-1:0] i_desired,

    // output channel
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      logic signed [SAMPLE_W-1:0] o_filter_out,
    output      logic signed [ERR_W-1:0]    o_error_out
);

    // accumulator holds NUM_TAPS terms of TERM_W bits without overflow
    localparam int ACC_W = TERM_W + $clog2(NUM_TAPS) + 1;
    localparam int CNT_W = $clog2(NUM_TAPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_TAPS - 1);

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [STEP_W-1:0]           r_step;

    // delay line: tap 0 is the newest sample
    logic signed [SAMPLE_W-1:0]  r_tap  [NUM_TAPS];
    logic signed [COEF_W-1:0]    r_coef [NUM_TAPS];

    logic signed [SAMPLE_W-1:0]  r_des;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [MUL_P_W-1:0]   r_prod;
    logic signed [MUE_W-1:0]     r_mue;
    logic signed [SAMPLE_W-1:0]  r_y;
    logic signed [ERR_W-1:0]     r_err;

    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_y;
    logic signed [ERR_W-1:0]     r_out_err;

    // sequencer controls
    t_mul_sel                    w_mul_sel;
    logic                        w_accept;
    logic                        w_rot_tap;
    logic                        w_rot_coef;
    logic                        w_wr_coef;
    logic                        w_acc_add;
    logic                        w_ld_out;

    // datapath
    logic signed [MUL_A_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0]   w_mul_b;
    logic signed [MUL_P_W-1:0]   w_prod;
    logic signed [TERM_W-1:0]    w_term;
    logic signed [ACC_W-1:0]     w_acc_sum;
    logic signed [SAMPLE_W-1:0]  w_y_sat;
    logic signed [DELTA_W-1:0]   w_delta;
    logic signed [COEF_SUM_W-1:0] w_coef_sum;
    logic signed [COEF_W-1:0]    w_coef_new;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_filter_out = r_out_y;
    assign o_error_out  = r_out_err;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_mul_sel  = MUL_MAC;
        w_accept   = 1'b0;
        w_rot_tap  = 1'b0;
        w_rot_coef = 1'b0;
        w_wr_coef  = 1'b0;
        w_acc_add  = 1'b0;
        w_ld_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    n_cnt    = '0;
                    n_state  = S_MAC;
                end
            end
            // coef[k] * tap[k], both lines rotate toward tap 0
            S_MAC: begin
                w_mul_sel  = MUL_MAC;
                w_rot_tap  = 1'b1;
                w_rot_coef = 1'b1;
                w_acc_add  = (r_cnt != '0);
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            // last filter product into the sum
            S_ACC: begin
                w_acc_add = 1'b1;
                n_state   = S_ERR;
            end
            S_ERR: begin
                n_state = S_MUE;
            end
            S_MUE: begin
                w_mul_sel = MUL_MUE;
                n_state   = S_UPD;
            end
            // mu*e * tap[k], while coefficient k-1 is written back from the registered product
            S_UPD: begin
                w_mul_sel = MUL_UPD;
                w_rot_tap = 1'b1;
                w_wr_coef = (r_cnt != '0);
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_WB;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_WB: begin
                w_wr_coef = 1'b1;
                n_state   = S_OUT;
            end
            // wait until the output register is free
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_ld_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // ---------------------------------------------------------------
    // shared multiplier
    // ---------------------------------------------------------------
    always_comb begin
        case (w_mul_sel)
            MUL_MAC: begin
                w_mul_a = MUL_A_W'(r_coef[0]);
                w_mul_b = MUL_B_W'(r_tap[0]);
            end
            MUL_MUE: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = signed'({1'b0, r_step});
            end
            MUL_UPD: begin
                w_mul_a = MUL_A_W'(r_mue);
                w_mul_b = MUL_B_W'(r_tap[0]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);

    // filter sum: floor shift by 20 is a plain bit select of the product
    assign w_term    = signed'(r_prod[TERM_HI:TERM_LO]);
    assign w_acc_sum = r_acc + ACC_W'(w_term);

    always_comb begin
        if (r_acc > ACC_W'(SAMPLE_MAX)) begin
            w_y_sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (r_acc < ACC_W'(SAMPLE_MIN)) begin
            w_y_sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            w_y_sat = r_acc[SAMPLE_W-1:0];
        end
    end

    // coefficient update with saturation to 24 bits
    assign w_delta    = signed'(r_prod[DELTA_HI:DELTA_LO]);
    assign w_coef_sum = COEF_SUM_W'(r_coef[0]) + COEF_SUM_W'(w_delta);

    always_comb begin
        if (w_coef_sum > COEF_MAX) begin
            w_coef_new = COEF_MAX[COEF_W-1:0];
        end else if (w_coef_sum < COEF_MIN) begin
            w_coef_new = COEF_MIN[COEF_W-1:0];
        end else begin
            w_coef_new = w_coef_sum[COEF_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // state lines
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_tap[i]  <= '0;
                r_coef[i] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_tap[0] <= i_sample_in;
                for (int i = 1; i < NUM_TAPS; i++) begin
                    r_tap[i] <= r_tap[i-1];
                end
            end else if (w_rot_tap) begin
                for (int i = 0; i < NUM_TAPS - 1; i++) begin
                    r_tap[i] <= r_tap[i+1];
                end
                r_tap[NUM_TAPS-1] <= r_tap[0];
            end
            if (w_rot_coef || w_wr_coef) begin
                for (int i = 0; i < NUM_TAPS - 1; i++) begin
                    r_coef[i] <= r_coef[i+1];
                end
                r_coef[NUM_TAPS-1] <= w_wr_coef ? w_coef_new : r_coef[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_des <= i_desired;
            r_acc <= '0;
        end else if (w_acc_add) begin
            r_acc <= w_acc_sum;
        end
        if (r_state == S_MUE) begin
            r_mue <= signed'(w_prod[MUE_W-1:0]);
        end else begin
            r_prod <= w_prod;
        end
        if (r_state == S_ERR) begin
            r_y   <= w_y_sat;
            r_err <= ERR_W'(r_des) - ERR_W'(w_y_sat);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out_y   <= r_y;
            r_out_err <= r_err;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && r_state == S_MAC && r_cnt == '0))
        else $error("block not busy after an input beat");

    a_mue_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUE) |-> ($past(r_state) == S_ERR))
        else $error("mu*error step entered out of order");

    a_idle_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("tap counter not cleared in idle");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld_out |=> (o_out_valid && o_in_ready
                      && o_filter_out == $past(r_y) && o_error_out == $past(r_err)))
        else $error("result not presented after the update pass");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && o_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("pending result would be overwritten");

endmodule

`default_nettype wire
